@@ rtl/assert_macros.svh @@
// Assertion macros shared by the RTL that checks itself.
// Needs a clock named clk and an active-low reset named arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, masked while reset is asserted.
`define RBD_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Same, but also checked during reset.
`define RBD_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/rbd_pkg.sv @@
// Shared types and constants for the ring buffer deque.
// No dependencies.
package rbd_pkg;

	localparam int RBD_DEPTH   = 128;
	localparam int RBD_DATA_W  = 32;

	localparam int KIND_W   = 3;
	localparam int VALUE_W  = 32;
	localparam int COUNT_W  = 8;
	localparam int DATA_W   = 32;
	localparam int LEN_W    = 8;
	localparam int STATUS_W = 2;

	typedef enum logic [KIND_W-1:0] {
		K_PUSH_FRONT = 3'd0,
		K_PUSH_BACK  = 3'd1,
		K_POP_FRONT  = 3'd2,
		K_READ       = 3'd3,
		K_TAKE       = 3'd4,
		K_DROP       = 3'd5
	} kind_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_DONE  = 2'd0,
		ST_FULL  = 2'd1,
		ST_RANGE = 2'd2
	} status_t;

	// Result of one request, minus the element read from the store.
	typedef struct packed {
		logic [LEN_W-1:0] length;
		logic             empty;
		status_t          status;
		logic             has_data;
	} rbd_res_t;

endpackage

@@ rtl/rbd_mem.sv @@
// Element store: one write port, one read port, registered read data.
// Depends on rbd_pkg.
module rbd_mem import rbd_pkg::*; #(
	parameter int DEPTH      = RBD_DEPTH,
	parameter int DATA_WIDTH = RBD_DATA_W
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [DATA_WIDTH-1:0]    wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [DATA_WIDTH-1:0]    rd_data
);

	logic [DATA_WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// read data holds while rd_en is low
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

@@ rtl/rbd_ctrl.sv @@
// Front pointer and fill count, request decode and store addressing.
// Depends on rbd_pkg.
module rbd_ctrl import rbd_pkg::*; #(
	parameter int DEPTH      = RBD_DEPTH,
	parameter int DATA_WIDTH = RBD_DATA_W
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     accept,
	input  logic [KIND_W-1:0]        kind,
	input  logic [VALUE_W-1:0]       value,
	input  logic [COUNT_W-1:0]       count,
	output logic                     wr_en,
	output logic [$clog2(DEPTH)-1:0] wr_addr,
	output logic [DATA_WIDTH-1:0]    wr_data,
	output logic                     rd_en,
	output logic [$clog2(DEPTH)-1:0] rd_addr,
	output rbd_res_t                 res
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int SUM_W = CNT_W + 1;
	localparam int CMP_W = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;

	logic [PTR_W-1:0] front_q, front_d;
	logic [CNT_W-1:0] fill_q, fill_d;
	logic             do_wr, do_rd;
	logic [CMP_W-1:0] n_cmp, fill_cmp;
	logic [CNT_W-1:0] n_cnt;
	logic             n_in;
	logic             full;
	status_t          st;
	logic             has;

	// pointer plus offset, offset at most DEPTH
	function automatic logic [PTR_W-1:0] wrap(input logic [PTR_W-1:0] p,
		input logic [CNT_W-1:0] o);
		logic [SUM_W-1:0] s;
		s = SUM_W'(p) + SUM_W'(o);
		if (s >= SUM_W'(DEPTH)) begin
			s = s - SUM_W'(DEPTH);
		end
		return PTR_W'(s);
	endfunction

	assign n_cmp    = CMP_W'(count);
	assign fill_cmp = CMP_W'(fill_q);
	assign n_cnt    = CNT_W'(count);
	assign n_in     = n_cmp < fill_cmp;
	assign full     = fill_q == CNT_W'(DEPTH);

	always_comb begin
		front_d = front_q;
		fill_d  = fill_q;
		do_wr   = 1'b0;
		do_rd   = 1'b0;
		wr_addr = front_q;
		rd_addr = front_q;
		st      = ST_DONE;
		has     = 1'b0;
		unique case (kind_t'(kind))
			K_PUSH_FRONT: begin
				if (full) begin
					st = ST_FULL;
				end else begin
					front_d = (front_q == '0) ? PTR_W'(DEPTH - 1) : front_q - 1'b1;
					wr_addr = front_d;
					do_wr   = 1'b1;
					fill_d  = fill_q + 1'b1;
				end
			end
			K_PUSH_BACK: begin
				if (full) begin
					st = ST_FULL;
				end else begin
					wr_addr = wrap(front_q, fill_q);
					do_wr   = 1'b1;
					fill_d  = fill_q + 1'b1;
				end
			end
			K_POP_FRONT: begin
				if (fill_q == '0) begin
					st = ST_RANGE;
				end else begin
					rd_addr = front_q;
					do_rd   = 1'b1;
					has     = 1'b1;
					front_d = (front_q == PTR_W'(DEPTH - 1)) ? '0 : front_q + 1'b1;
					fill_d  = fill_q - 1'b1;
				end
			end
			K_READ: begin
				if (n_in) begin
					rd_addr = wrap(front_q, n_cnt);
					do_rd   = 1'b1;
					has     = 1'b1;
				end else begin
					st = ST_RANGE;
				end
			end
			K_TAKE: begin
				if (n_in) begin
					fill_d = n_cnt;
				end
			end
			K_DROP: begin
				if (n_in) begin
					front_d = wrap(front_q, n_cnt);
					fill_d  = fill_q - n_cnt;
				end else begin
					front_d = wrap(front_q, fill_q);
					fill_d  = '0;
				end
			end
			default: begin
			end
		endcase
	end

	assign wr_en   = accept && do_wr;
	assign rd_en   = accept && do_rd;
	assign wr_data = DATA_WIDTH'(value);

	assign res.length   = LEN_W'(fill_d);
	assign res.empty    = fill_d == '0;
	assign res.status   = st;
	assign res.has_data = has;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q <= '0;
			fill_q  <= '0;
		end else if (accept) begin
			front_q <= front_d;
			fill_q  <= fill_d;
		end
	end

endmodule

@@ rtl/ring_buffer_deque.sv @@
// Ring buffer deque top level: request channel, result channel, output stage.
// Depends on rbd_pkg, rbd_ctrl, rbd_mem and assert_macros.svh.
//
// Usage:
//  - Request beat (in_valid/in_stall): kind, value, count. Six operations:
//    push front, push back, pop front, read at position, take, drop.
//  - Result beat (out_valid/out_stall): data, length, empty_res, status.
//    Exactly one result beat per request beat, in request order.
//  - A result is registered and is valid the cycle after its request is accepted.
//  - One request per cycle while in_stall is low. Pointer and count updates finish in
//    the accept cycle; the single read port of the element store returns
//    data in the next cycle straight into the result stage.
//  - The result stage holds one beat. While it is full and out_stall is
//    high, in_stall is raised and the store read data is frozen.
//  - Reset (arst_n low) empties the list: front pointer and fill count go
//    to zero, the result stage is emptied. The store itself is not cleared;
//    only entries inside the list are ever read.
//  - Errors do not stall: a push on a full list, a pop on an empty list or
//    a read out of range returns a status and leaves the list unchanged.
module ring_buffer_deque import rbd_pkg::*; #(
	parameter int DEPTH      = RBD_DEPTH,
	parameter int DATA_WIDTH = RBD_DATA_W
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [KIND_W-1:0]   kind,
	input  logic [VALUE_W-1:0]  value,
	input  logic [COUNT_W-1:0]  count,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [DATA_W-1:0]   data,
	output logic [LEN_W-1:0]    length,
	output logic                empty_res,
	output logic [STATUS_W-1:0] status
);

	`include "assert_macros.svh"

	localparam int PTR_W = $clog2(DEPTH);
	localparam logic [LEN_W-1:0] LEN_FULL = LEN_W'(DEPTH);

	logic                  in_accept;
	logic                  wr_en, rd_en;
	logic [PTR_W-1:0]      wr_addr, rd_addr;
	logic [DATA_WIDTH-1:0] wr_data, rd_data;
	rbd_res_t              res;

	// result stage
	logic                  valid_s1;
	rbd_res_t              res_s1;

	assign in_stall  = valid_s1 && out_stall;
	assign in_accept = in_valid && !in_stall;

	rbd_ctrl #(
		.DEPTH      (DEPTH),
		.DATA_WIDTH (DATA_WIDTH)
	) u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.accept  (in_accept),
		.kind    (kind),
		.value   (value),
		.count   (count),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.res     (res)
	);

	rbd_mem #(
		.DEPTH      (DEPTH),
		.DATA_WIDTH (DATA_WIDTH)
	) u_mem (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_accept) begin
			valid_s1 <= 1'b1;
		end else if (!out_stall) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			res_s1 <= res;
		end
	end

	// store data lines up with the result stage; zero when nothing was read
	assign out_valid = valid_s1;
	assign data      = res_s1.has_data ? DATA_W'(rd_data) : '0;
	assign length    = res_s1.length;
	assign empty_res = res_s1.empty;
	assign status    = res_s1.status;

	`RBD_ASSERT(a_result_follows, in_accept |=> out_valid, "accepted beat gave no result")
	`RBD_ASSERT(a_full_len, (out_valid && status == ST_FULL) |-> (length == LEN_FULL),
		"full status while list not full")
	`RBD_ASSERT(a_err_nodata, (out_valid && status == ST_RANGE) |-> (data == '0),
		"range error carries data")
	`RBD_ASSERT_ALWAYS(a_reset_empty, !arst_n |-> !out_valid, "result valid in reset")

endmodule

@@ verif/ring_buffer_deque_test.sv @@
// Self-checking testbench for the ring buffer deque: directed and random requests.
// Depends on rbd_pkg and the ring_buffer_deque RTL; the checker is a shadow deque class.
module ring_buffer_deque_test import rbd_pkg::*;;

	// Pointer width follows the store depth from the package.
	localparam int PTR_W          = $clog2(RBD_DEPTH);
	// A result beat shows up in the cycle after its request beat.
	localparam int RESULT_LATENCY = 1;
	// Generous wall on total simulation time.
	localparam int RUN_LIMIT      = 2_000_000;
	// Percent of cycles in which either side idles.
	localparam int IDLE_PCT       = 37;
	// Kinds outside the six operations; the block must ignore them.
	localparam logic [KIND_W-1:0] K_SPARE_LO = 3'd6;
	localparam logic [KIND_W-1:0] K_SPARE_HI = 3'd7;

	typedef struct {
		logic [DATA_W-1:0]   data;
		logic [LEN_W-1:0]    length;
		logic                empty;
		logic [STATUS_W-1:0] status;
	} deque_result_t;

	// Shadow deque: mirrors the store, front pointer and fill count, and keeps
	// the results still owed by the block in request order.
	class deque_shadow;
		logic [DATA_W-1:0] store [RBD_DEPTH];
		logic [PTR_W-1:0]  front;
		logic [LEN_W-1:0]  fill;
		deque_result_t     owed [$];
		int errors;
		int requests;
		int results;
		int full_hits;
		int range_hits;
		int peak;

		function new();
			front      = '0;
			fill       = '0;
			errors     = 0;
			requests   = 0;
			results    = 0;
			full_hits  = 0;
			range_hits = 0;
			peak       = 0;
		endfunction

		function int pending();
			return owed.size();
		endfunction

		// Apply one accepted request and queue the result it must produce.
		function void accept_request(logic [KIND_W-1:0] k, logic [VALUE_W-1:0] v,
				logic [COUNT_W-1:0] n);
			deque_result_t r;
			logic [PTR_W-1:0] slot;
			r.data   = '0;
			r.status = ST_DONE;
			case (k)
				K_PUSH_FRONT: begin
					if (fill >= RBD_DEPTH) begin
						r.status = ST_FULL;
					end else begin
						front        = front - 1'b1;
						store[front] = v;
						fill         = fill + 1'b1;
					end
				end
				K_PUSH_BACK: begin
					if (fill >= RBD_DEPTH) begin
						r.status = ST_FULL;
					end else begin
						slot        = front + fill[PTR_W-1:0];
						store[slot] = v;
						fill        = fill + 1'b1;
					end
				end
				K_POP_FRONT: begin
					if (fill == 0) begin
						r.status = ST_RANGE;
					end else begin
						r.data = store[front];
						front  = front + 1'b1;
						fill   = fill - 1'b1;
					end
				end
				K_READ: begin
					if (n >= fill) begin
						r.status = ST_RANGE;
					end else begin
						slot   = front + n[PTR_W-1:0];
						r.data = store[slot];
					end
				end
				K_TAKE: begin
					if (n < fill) fill = n;
				end
				K_DROP: begin
					// Dropping everything still moves the front past the old list.
					if (n >= fill) begin
						front = front + fill[PTR_W-1:0];
						fill  = '0;
					end else begin
						front = front + n[PTR_W-1:0];
						fill  = fill - n;
					end
				end
				default: ;
			endcase
			r.length = fill;
			r.empty  = (fill == 0);
			if (r.status == ST_FULL) full_hits++;
			if (r.status == ST_RANGE) range_hits++;
			if (int'(fill) > peak) peak = int'(fill);
			requests++;
			owed.push_back(r);
		endfunction

		task report(string what, logic [DATA_W-1:0] got, logic [DATA_W-1:0] want);
			errors++;
			$display("mismatch at result %0d: %s got 0x%0h, want 0x%0h",
				results, what, got, want);
		endtask

		task match_result(logic [DATA_W-1:0] d, logic [LEN_W-1:0] len, logic e,
				logic [STATUS_W-1:0] s);
			deque_result_t w;
			results++;
			if (owed.size() == 0) begin
				report("unrequested beat, data", d, '0);
			end else begin
				w = owed.pop_front();
				if (d !== w.data) report("data", d, w.data);
				if (len !== w.length) report("length", DATA_W'(len), DATA_W'(w.length));
				if (e !== w.empty) report("empty_res", DATA_W'(e), DATA_W'(w.empty));
				if (s !== w.status) report("status", DATA_W'(s), DATA_W'(w.status));
			end
		endtask
	endclass

	logic                clk;
	logic                arst_n;
	logic                in_valid;
	logic                in_stall;
	logic [KIND_W-1:0]   kind;
	logic [VALUE_W-1:0]  value;
	logic [COUNT_W-1:0]  count;
	logic                out_valid;
	logic                out_stall;
	logic [DATA_W-1:0]   data;
	logic [LEN_W-1:0]    length;
	logic                empty_res;
	logic [STATUS_W-1:0] status;

	deque_shadow shadow;
	// When set, neither side idles.
	bit steady;

	ring_buffer_deque uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.kind      (kind),
		.value     (value),
		.count     (count),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.data      (data),
		.length    (length),
		.empty_res (empty_res),
		.status    (status)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Hard stop in case a handshake never completes.
	initial begin
		#(RUN_LIMIT);
		$display("ring_buffer_deque_test: FAIL");
		$finish;
	end

	// Beat monitor: sampled at the rising edge, before the block updates.
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall)
				shadow.accept_request(kind, value, count);
			if (out_valid && !out_stall)
				shadow.match_result(data, length, empty_res, status);
		end
	end

	// Result side: random back-pressure, none while steady.
	initial begin
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			out_stall <= !steady && ($urandom_range(0, 99) < IDLE_PCT);
		end
	end

	// Drive one request beat; starts and returns on a falling edge.
	task automatic send(input logic [KIND_W-1:0] k, input logic [VALUE_W-1:0] v,
			input logic [COUNT_W-1:0] n);
		while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		kind     <= k;
		value    <= v;
		count    <= n;
		do @(posedge clk); while (in_stall);
		@(negedge clk);
	endtask

	// Sender holds off until every owed result has come back.
	task automatic drain();
		in_valid <= 1'b0;
		while (shadow.pending() != 0) @(negedge clk);
		repeat (RESULT_LATENCY + 2) @(negedge clk);
	endtask

	// One random request; push_pct and pop_pct shape where the length drifts.
	task automatic random_op(input int push_pct, input int pop_pct);
		int roll;
		int len;
		logic [KIND_W-1:0]  k;
		logic [VALUE_W-1:0] v;
		logic [COUNT_W-1:0] n;
		len  = int'(shadow.fill);
		roll = $urandom_range(0, 99);
		n    = COUNT_W'($urandom_range(0, 255));
		if (roll < push_pct) begin
			k = $urandom_range(0, 1) ? K_PUSH_BACK : K_PUSH_FRONT;
		end else if (roll < push_pct + pop_pct) begin
			k = K_POP_FRONT;
		end else begin
			roll = $urandom_range(0, 99);
			if (roll < 45) begin
				k = K_READ;
				// Mostly positions inside the list, some far outside.
				if (len != 0 && $urandom_range(0, 3) != 0)
					n = COUNT_W'($urandom_range(0, len - 1));
			end else if (roll < 70) begin
				k = K_TAKE;
				// Mostly trims near the current length.
				if ($urandom_range(0, 3) != 0)
					n = (len > 3) ? COUNT_W'($urandom_range(len - 3, len + 1))
						: COUNT_W'($urandom_range(0, len + 1));
			end else if (roll < 95) begin
				k = K_DROP;
				if ($urandom_range(0, 4) != 0) n = COUNT_W'($urandom_range(0, 4));
			end else begin
				k = $urandom_range(0, 1) ? K_SPARE_HI : K_SPARE_LO;
			end
		end
		case ($urandom_range(0, 9))
			0:       v = '0;
			1:       v = '1;
			default: v = $urandom();
		endcase
		send(k, v, n);
	endtask

	initial begin
		shadow   = new();
		steady   = 1'b0;
		arst_n   = 1'b0;
		in_valid = 1'b0;
		kind     = '0;
		value    = '0;
		count    = '0;
		repeat (12) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed: empty-list errors, spare kinds, value and count extremes,
		// over-long take, drop of everything, pop back down to empty.
		send(K_POP_FRONT,  32'h0,        8'd0);
		send(K_READ,       32'h0,        8'd0);
		send(K_TAKE,       32'h0,        8'd0);
		send(K_DROP,       32'h0,        8'd5);
		send(K_SPARE_LO,   32'hFFFFFFFF, 8'd255);
		send(K_SPARE_HI,   32'h0,        8'd0);
		send(K_PUSH_BACK,  32'h0,        8'd0);
		send(K_PUSH_BACK,  32'hFFFFFFFF, 8'd0);
		send(K_PUSH_FRONT, 32'h12345678, 8'd0);
		send(K_PUSH_FRONT, 32'h0,        8'd0);
		send(K_READ,       32'h0,        8'd0);
		send(K_READ,       32'h0,        8'd3);
		send(K_READ,       32'h0,        8'd4);
		send(K_READ,       32'h0,        8'd128);
		send(K_READ,       32'h0,        8'd255);
		send(K_TAKE,       32'h0,        8'd200);
		send(K_DROP,       32'h0,        8'd0);
		send(K_POP_FRONT,  32'h0,        8'd0);
		send(K_TAKE,       32'h0,        8'd1);
		send(K_PUSH_BACK,  32'hAAAAAAAA, 8'd0);
		send(K_DROP,       32'h0,        8'd255);
		send(K_PUSH_FRONT, 32'h55555555, 8'd0);
		send(K_READ,       32'h0,        8'd0);
		send(K_POP_FRONT,  32'h0,        8'd0);
		send(K_POP_FRONT,  32'h0,        8'd0);

		// Random, no idling on either side.
		steady = 1'b1;
		repeat (200) random_op(40, 20);
		steady = 1'b0;
		// Push-heavy: grows to capacity and keeps knocking on the full list.
		repeat (500) random_op(75, 5);
		drain();
		// Pop-heavy back toward empty, then a balanced mix.
		repeat (300) random_op(20, 50);
		repeat (300) random_op(40, 25);

		drain();
		repeat (RESULT_LATENCY + 4) @(negedge clk);
		$display("covered %0d requests and %0d results, longest list %0d",
			shadow.requests, shadow.results, shadow.peak);
		$display("%0d pushes hit a full list, %0d empty or out-of-range accesses",
			shadow.full_hits, shadow.range_hits);
		if (shadow.errors == 0) begin
			$display("ring_buffer_deque_test: PASS");
		end else begin
			$display("ring_buffer_deque_test: FAIL");
		end
		$finish;
	end

endmodule
